>>> sv/waq_pkg.sv
// waq_pkg: shared constants and types for the waypoint arrival qualifier.
// Register indexes, register reset values and the root unit status struct.
// No dependencies.
`default_nettype none

package waq_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_APPROACH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRECISION = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_NOISE     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CONVERGE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DWELL     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIN_NEAR  = 3'd5;

  localparam logic [15:0] APPROACH_RST  = 16'd2000;
  localparam logic [15:0] PRECISION_RST = 16'd600;
  localparam logic [15:0] NOISE_RST     = 16'd250;
  localparam logic [15:0] CONVERGE_RST  = 16'd50;
  localparam logic [15:0] DWELL_RST     = 16'd1000;
  localparam logic [7:0]  MIN_NEAR_RST  = 8'd8;

  localparam int DistW = 22;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

>>> sv/waq_isqrt.sv
// waq_isqrt: bit-serial floor square root, one root bit per cycle.
// Uses waq_pkg for the status struct.
`default_nettype none

module waq_isqrt import waq_pkg::*; #(
  parameter int RW = 22
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [2*RW-1:0] radicand,
  output sqrt_stat_t           stat,
  output logic [RW-1:0]        root
);

  localparam int CntW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_r, rad_nxt;
  logic [RW+1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;
  logic            ge;

  assign rem_sh = {rem_r, rad_r[2*RW-1:2*RW-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[2*RW-3:0], 2'b00};
      rem_nxt  = ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
      root_nxt = {root_r[RW-2:0], ge};
      if (cnt_r == CntW'(RW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

`default_nettype wire

>>> sv/waypoint_arrival_qualifier.sv
// waypoint_arrival_qualifier: distance, window statistics and arrival decision.
// Depends on waq_pkg and waq_isqrt.
//
//  channel | direction | handshake            | payload
//  in_     | sink      | in_valid / in_stall  | targets, poses, time_ms, restart
//  out_    | source    | out_valid / out_stall| reached, near, distance_mm
//  cfg_    | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A transaction passes the states SQ, ROOT, WIN, WALK, NMUL, CALC and DEC in that
// order; its result is registered on leaving DEC and the next one is taken in IDLE.
// The walk over the window grows with the window fill.
// One shared multiplier serves squares, sums of squares and thresholds.
// Reset is synchronous; the window needs none. in_stall is high while a
// transaction is in work; a result waits in the output register under out_stall.
`default_nettype none

module waypoint_arrival_qualifier import waq_pkg::*; #(
  parameter int WINDOW   = 10,
  parameter int POS_BITS = 21
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [POS_BITS-1:0] in_target_x,
  input  wire logic [POS_BITS-1:0] in_target_y,
  input  wire logic [POS_BITS-1:0] in_target_z,
  input  wire logic [POS_BITS-1:0] in_pose_x,
  input  wire logic [POS_BITS-1:0] in_pose_y,
  input  wire logic [POS_BITS-1:0] in_pose_z,
  input  wire logic [31:0]         in_time_ms,
  input  wire logic                in_restart,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_reached,
  output logic                     out_near,
  output logic [DistW-1:0]         out_distance_mm,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  localparam int P   = POS_BITS;
  localparam int DW  = P + 1;
  localparam int NW  = $clog2(WINDOW + 1);
  localparam int IW  = $clog2(WINDOW);
  localparam int SW  = DW + NW;
  localparam int QW  = 2 * DW + NW;
  localparam int DV  = 2 * SW;
  localparam int MW  = (SW > 32) ? SW : 32;
  localparam int PW  = 2 * MW;
  localparam int N2W = 32 + 2 * NW;
  localparam int CB  = (DV > N2W) ? DV : N2W;
  localparam int CW  = CB + 5;
  localparam int OW  = DW + 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_ROOT = 4'd2;
  localparam logic [3:0] ST_WIN  = 4'd3;
  localparam logic [3:0] ST_WALK = 4'd4;
  localparam logic [3:0] ST_NMUL = 4'd5;
  localparam logic [3:0] ST_CALC = 4'd6;
  localparam logic [3:0] ST_DEC  = 4'd7;

  logic [3:0]      state_r, state_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [NW-1:0]   fill_r, fill_nxt;
  logic            near_r, near_nxt;
  logic [7:0]      count_r, count_nxt;
  logic [31:0]     since_r, since_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            ph_r, ph_nxt;

  logic [15:0]     app_r, app_nxt;
  logic [15:0]     prec_r, prec_nxt;
  logic [15:0]     noise_r, noise_nxt;
  logic [15:0]     conv_r, conv_nxt;
  logic [15:0]     dwell_r, dwell_nxt;
  logic [7:0]      minn_r, minn_nxt;

  logic [P-1:0]    adx_r, adx_nxt;
  logic [P-1:0]    ady_r, ady_nxt;
  logic [P-1:0]    adz_r, adz_nxt;
  logic [31:0]     time_r, time_nxt;
  logic [2*DW-1:0] s_r, s_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [DW-1:0]   win_r [WINDOW];
  logic [DW-1:0]   win_nxt [WINDOW];
  logic [NW-1:0]   idx_r, idx_nxt;
  logic [SW-1:0]   sum_r, sum_nxt;
  logic [QW-1:0]   sumsq_r, sumsq_nxt;
  logic [DW+1:0]   so_r, so_nxt;
  logic [DW+1:0]   sn_r, sn_nxt;
  logic [DV-1:0]   msh_r, msh_nxt;
  logic [NW-1:0]   nsh_r, nsh_nxt;
  logic [DV-1:0]   nsq_r, nsq_nxt;
  logic [DV-1:0]   ssq_r, ssq_nxt;
  logic [31:0]     nz_r, nz_nxt;
  logic [N2W-1:0]  noise2_r, noise2_nxt;
  logic [16+NW-1:0] an_r, an_nxt;
  logic [16+NW-1:0] pn_r, pn_nxt;
  logic [PW-1:0]   mp_r;
  logic            reached_r, reached_nxt;
  logic            onear_r, onear_nxt;
  logic [DistW-1:0] dist_r, dist_nxt;

  logic [MW-1:0]   ma, mb;
  logic            sq_start;
  sqrt_stat_t      sq_stat;
  logic [DW-1:0]   sq_root;

  logic [P:0]      dx, dy, dz;
  logic [P-1:0]    adx, ady, adz;

  logic [CW-1:0]   dvar, noise2, sum_c, an_c, pn_c;
  logic signed [CW-1:0] rdiff, cv;
  logic            w_app, w_prec, stable, conv_ok, diverge, stat_near, far;
  logic [7:0]      count_inc;
  logic [31:0]     elapsed;

  waq_isqrt #(.RW(DW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (s_r),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  assign dx  = {in_target_x[P-1], in_target_x} - {in_pose_x[P-1], in_pose_x};
  assign dy  = {in_target_y[P-1], in_target_y} - {in_pose_y[P-1], in_pose_y};
  assign dz  = {in_target_z[P-1], in_target_z} - {in_pose_z[P-1], in_pose_z};
  assign adx = dx[P] ? P'(-dx) : dx[P-1:0];
  assign ady = dy[P] ? P'(-dy) : dy[P-1:0];
  assign adz = dz[P] ? P'(-dz) : dz[P-1:0];

  assign dvar   = CW'(nsq_r) - CW'(ssq_r);
  assign noise2 = CW'(noise2_r);
  assign sum_c  = CW'(sum_r);
  assign an_c   = CW'(an_r);
  assign pn_c   = CW'(pn_r);
  assign cv     = $signed(CW'(conv_r));
  assign rdiff  = (fill_r >= NW'(6)) ?
                  ($signed(CW'(so_r) - CW'(sn_r)) <<< 3) : '0;
  assign w_app     = sum_c < an_c;
  assign w_prec    = sum_c < pn_c;
  assign stable    = (dvar < noise2) && (fill_r >= NW'(5));
  assign conv_ok   = (rdiff + cv * 9) > 0;
  assign diverge   = (rdiff + cv * 18) < 0;
  assign stat_near = ((dvar << 2) < noise2) && w_prec;
  assign far       = ((sum_c << 1) > an_c * 3) || (dvar > noise2 * 9) || diverge;
  assign count_inc = (count_r == 8'd255) ? count_r : count_r + 8'd1;
  assign elapsed   = time_r - since_r;

  always_comb begin
    logic [SW-1:0] sum_a;
    logic [QW-1:0] sumsq_a;
    logic [DW-1:0] cur;
    logic          rch;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    near_nxt      = near_r;
    count_nxt     = count_r;
    since_nxt     = since_r;
    out_valid_nxt = out_valid_r && out_stall;
    ph_nxt        = ph_r;
    app_nxt       = app_r;
    prec_nxt      = prec_r;
    noise_nxt     = noise_r;
    conv_nxt      = conv_r;
    dwell_nxt     = dwell_r;
    minn_nxt      = minn_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    adz_nxt       = adz_r;
    time_nxt      = time_r;
    s_nxt         = s_r;
    d_nxt         = d_r;
    win_nxt       = win_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    so_nxt        = so_r;
    sn_nxt        = sn_r;
    msh_nxt       = msh_r;
    nsh_nxt       = nsh_r;
    nsq_nxt       = nsq_r;
    ssq_nxt       = ssq_r;
    nz_nxt        = nz_r;
    noise2_nxt    = noise2_r;
    an_nxt        = an_r;
    pn_nxt        = pn_r;
    reached_nxt   = reached_r;
    onear_nxt     = onear_r;
    dist_nxt      = dist_r;
    ma            = '0;
    mb            = '0;
    sq_start      = 1'b0;
    cur           = win_r[idx_r[IW-1:0]];
    sum_a         = sum_r + SW'(cur);
    sumsq_a       = sumsq_r + QW'(mp_r[2*DW-1:0]);
    rch           = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_APPROACH:  app_nxt   = cfg_data;
        CFG_PRECISION: prec_nxt  = cfg_data;
        CFG_NOISE:     noise_nxt = cfg_data;
        CFG_CONVERGE:  conv_nxt  = cfg_data;
        CFG_DWELL:     dwell_nxt = cfg_data;
        CFG_MIN_NEAR:  minn_nxt  = cfg_data[7:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          adx_nxt  = adx;
          ady_nxt  = ady;
          adz_nxt  = adz;
          time_nxt = in_time_ms;
          if (in_restart) begin
            fill_nxt  = '0;
            near_nxt  = 1'b0;
            count_nxt = '0;
          end
          cnt_nxt   = '0;
          s_nxt     = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        unique case (cnt_r)
          3'd0: ma = MW'(adx_r);
          3'd1: ma = MW'(ady_r);
          3'd2: ma = MW'(adz_r);
          default: ma = '0;
        endcase
        mb = ma;
        if (cnt_r != 3'd0) s_nxt = s_r + mp_r[2*DW-1:0];
        if (cnt_r == 3'd3) begin
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_ROOT: begin
        if (!sq_stat.busy && !sq_stat.done && cnt_r == 3'd3) begin
          sq_start = 1'b1;
          cnt_nxt  = '0;
        end
        if (sq_stat.done) begin
          d_nxt     = sq_root;
          state_nxt = ST_WIN;
        end
      end
      ST_WIN: begin
        if (fill_r == NW'(WINDOW)) begin
          for (int k = 0; k < WINDOW - 1; k++) begin
            win_nxt[k] = win_r[k+1];
          end
          win_nxt[WINDOW-1] = d_r;
        end else begin
          win_nxt[fill_r[IW-1:0]] = d_r;
          fill_nxt = fill_r + 1'b1;
        end
        idx_nxt   = '0;
        sum_nxt   = '0;
        sumsq_nxt = '0;
        so_nxt    = '0;
        sn_nxt    = '0;
        ph_nxt    = 1'b0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        ma = MW'(cur);
        mb = MW'(cur);
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt    = 1'b0;
          sum_nxt   = sum_a;
          sumsq_nxt = sumsq_a;
          if (idx_r < NW'(3)) so_nxt = so_r + OW'(cur);
          if ((NW+1)'(idx_r) + (NW+1)'(3) >= (NW+1)'(fill_r)) sn_nxt = sn_r + OW'(cur);
          if (idx_r == fill_r - 1'b1) begin
            msh_nxt   = DV'(sumsq_a);
            nsh_nxt   = fill_r;
            nsq_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_NMUL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_NMUL: begin
        if (nsh_r[0]) nsq_nxt = nsq_r + msh_r;
        msh_nxt = msh_r << 1;
        nsh_nxt = nsh_r >> 1;
        if (cnt_r == 3'(NW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_CALC;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_CALC: begin
        unique case (cnt_r)
          3'd0: begin
            ma = MW'(sum_r);
            mb = MW'(sum_r);
          end
          3'd1: begin
            ma      = MW'(noise_r);
            mb      = MW'(noise_r);
            ssq_nxt = mp_r[DV-1:0];
          end
          3'd2: begin
            ma     = MW'(fill_r);
            mb     = MW'(fill_r);
            nz_nxt = mp_r[31:0];
          end
          3'd3: begin
            ma = MW'(nz_r);
            mb = MW'(mp_r[2*NW-1:0]);
          end
          3'd4: begin
            ma         = MW'(app_r);
            mb         = MW'(fill_r);
            noise2_nxt = mp_r[N2W-1:0];
          end
          3'd5: begin
            ma     = MW'(prec_r);
            mb     = MW'(fill_r);
            an_nxt = mp_r[16+NW-1:0];
          end
          default: pn_nxt = mp_r[16+NW-1:0];
        endcase
        if (cnt_r == 3'd6) begin
          state_nxt = ST_DEC;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_DEC: begin
        if (!out_valid_r || !out_stall) begin
          if (w_app && !near_r) begin
            near_nxt  = 1'b1;
            since_nxt = time_r;
            count_nxt = 8'd1;
          end else begin
            if (near_r) begin
              count_nxt = count_inc;
              if (w_prec && stable && conv_ok &&
                  (((elapsed >= 32'(dwell_r)) && (count_inc >= minn_r)) || stat_near)) begin
                rch = 1'b1;
              end
            end
            if (!rch && near_r && far) begin
              near_nxt  = 1'b0;
              count_nxt = '0;
            end
          end
          reached_nxt   = rch;
          onear_nxt     = near_nxt;
          dist_nxt      = DistW'(d_r);
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      near_r      <= 1'b0;
      count_r     <= '0;
      since_r     <= '0;
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
      app_r       <= APPROACH_RST;
      prec_r      <= PRECISION_RST;
      noise_r     <= NOISE_RST;
      conv_r      <= CONVERGE_RST;
      dwell_r     <= DWELL_RST;
      minn_r      <= MIN_NEAR_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      near_r      <= near_nxt;
      count_r     <= count_nxt;
      since_r     <= since_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
      app_r       <= app_nxt;
      prec_r      <= prec_nxt;
      noise_r     <= noise_nxt;
      conv_r      <= conv_nxt;
      dwell_r     <= dwell_nxt;
      minn_r      <= minn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adx_r     <= adx_nxt;
    ady_r     <= ady_nxt;
    adz_r     <= adz_nxt;
    time_r    <= time_nxt;
    s_r       <= s_nxt;
    d_r       <= d_nxt;
    win_r     <= win_nxt;
    idx_r     <= idx_nxt;
    sum_r     <= sum_nxt;
    sumsq_r   <= sumsq_nxt;
    so_r      <= so_nxt;
    sn_r      <= sn_nxt;
    msh_r     <= msh_nxt;
    nsh_r     <= nsh_nxt;
    nsq_r     <= nsq_nxt;
    ssq_r     <= ssq_nxt;
    nz_r      <= nz_nxt;
    noise2_r  <= noise2_nxt;
    an_r      <= an_nxt;
    pn_r      <= pn_nxt;
    mp_r      <= ma * mb;
    reached_r <= reached_nxt;
    onear_r   <= onear_nxt;
    dist_r    <= dist_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_reached     = reached_r;
  assign out_near        = onear_r;
  assign out_distance_mm = dist_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NW'(WINDOW))
    else $error("window fill beyond depth");

  a_near_count: assert property (@(posedge clk) disable iff (!rst_n)
    near_r == (count_r != 8'd0))
    else $error("near flag and near count disagree");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted a transaction without going busy");

  a_result_from_dec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DEC)
    else $error("result raised outside the decision step");

endmodule

`default_nettype wire
